>>> sv/y86ie_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// y86ie_pkg
// Shared types, codes and helpers of the Y86-64 instruction execute core.
// ---------------------------------------------------------------------------
package y86ie_pkg;

  localparam int MEM_BYTES_DEF = 4096;
  localparam int NUM_REGS      = 15;
  localparam logic [3:0] REG_NONE = 4'd15;
  localparam logic [3:0] REG_SP   = 4'd4;

  localparam logic [3:0] I_HALT  = 4'd0;
  localparam logic [3:0] I_NOP   = 4'd1;
  localparam logic [3:0] I_CMOV  = 4'd2;
  localparam logic [3:0] I_IRMOV = 4'd3;
  localparam logic [3:0] I_RMMOV = 4'd4;
  localparam logic [3:0] I_MRMOV = 4'd5;
  localparam logic [3:0] I_OPQ   = 4'd6;
  localparam logic [3:0] I_JXX   = 4'd7;
  localparam logic [3:0] I_CALL  = 4'd8;
  localparam logic [3:0] I_RET   = 4'd9;
  localparam logic [3:0] I_PUSH  = 4'd10;
  localparam logic [3:0] I_POP   = 4'd11;

  localparam logic [3:0] F_ADD = 4'd0;
  localparam logic [3:0] F_SUB = 4'd1;
  localparam logic [3:0] F_AND = 4'd2;
  localparam logic [3:0] F_XOR = 4'd3;

  localparam logic [3:0] C_ALW = 4'd0;
  localparam logic [3:0] C_LE  = 4'd1;
  localparam logic [3:0] C_L   = 4'd2;
  localparam logic [3:0] C_E   = 4'd3;
  localparam logic [3:0] C_NE  = 4'd4;
  localparam logic [3:0] C_GE  = 4'd5;
  localparam logic [3:0] C_G   = 4'd6;

  typedef enum logic [1:0] {ST_AOK, ST_HLT, ST_ADR, ST_INS} status_t;

  typedef logic [63:0] regs_t [NUM_REGS];

  typedef struct packed {
    logic        mode;
    logic [3:0]  icode;
    logic [3:0]  ifun;
    logic [3:0]  reg_a;
    logic [3:0]  reg_b;
    logic [63:0] const_value;
    logic [63:0] fall_through_pc;
    logic [11:0] load_address;
    logic [63:0] load_word;
  } item_t;

  typedef struct packed {
    logic        we;
    logic        re;
    logic [63:0] addr;
    logic [63:0] wdata;
  } memreq_t;

  typedef struct packed {
    status_t     st;
    logic        commit;
    logic        is_ret;
    logic [63:0] npc;
    logic [3:0]  dst_e;
    logic [3:0]  dst_m;
    logic [63:0] val_e;
    logic        cnd;
    logic        fl_we;
    logic        zf;
    logic        sf;
    logic        of;
    logic        mem_rd;
  } wb_t;

  function automatic logic cond_eval(input logic [3:0] fn, input logic zf,
                                     input logic sf, input logic of);
    logic lt;
    lt = sf ^ of;
    unique case (fn)
      C_ALW:   return 1'b1;
      C_LE:    return lt | zf;
      C_L:     return lt;
      C_E:     return zf;
      C_NE:    return ~zf;
      C_GE:    return ~lt;
      C_G:     return ~lt & ~zf;
      default: return 1'b0;
    endcase
  endfunction

endpackage

>>> sv/y86ie_mem.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// y86ie_mem
// Byte data memory in eight banks, so an unaligned eight-byte word is one
// access. Read data is registered. Cleared row by row after reset.
// ---------------------------------------------------------------------------
module y86ie_mem import y86ie_pkg::*; #(
  parameter int MEM_BYTES = MEM_BYTES_DEF,
  parameter int AW        = $clog2(MEM_BYTES)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [63:0]   wdata,
  output logic [63:0]   rdata,
  output logic          busy
);

  localparam int ROWS = MEM_BYTES / 8;
  localparam int RW   = AW - 3;

  logic [RW-1:0] clr_row;
  logic          clearing;
  logic [2:0]    rd_lo;
  logic [7:0]    bank_q [8];

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row  <= '0;
    end else if (clearing) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == RW'(ROWS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_lo <= addr[2:0];
    end
  end

  for (genvar b = 0; b < 8; b++) begin : g_bank
    logic [7:0]    mem [ROWS];
    logic [2:0]    off;
    logic [RW-1:0] row;
    logic [63:0]   shifted;

    // Bytes of the word below the start column land one row further on.
    assign off     = 3'(b) - addr[2:0];
    assign row     = addr[AW-1:3] + RW'(3'(b) < addr[2:0]);
    assign shifted = wdata >> {off, 3'b000};

    always_ff @(posedge clk) begin
      if (clearing) begin
        mem[clr_row] <= 8'd0;
      end else if (we) begin
        mem[row] <= shifted[7:0];
      end
      if (re) begin
        bank_q[b] <= mem[row];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rdata[8*i +: 8] = bank_q[3'(rd_lo + 3'(i))];
    end
  end

  assign busy = clearing;

endmodule

>>> sv/y86ie_exec.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// y86ie_exec
// Decode, execute and memory request for one instruction or preload item.
// ---------------------------------------------------------------------------
module y86ie_exec import y86ie_pkg::*; #(
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input  item_t       item,
  input  regs_t       regs,
  input  status_t     status,
  input  logic [63:0] pc,
  input  logic        zf,
  input  logic        sf,
  input  logic        of,
  output memreq_t     req,
  output wb_t         wb
);

  localparam logic [63:0] LAST_OK = 64'(MEM_BYTES - 8);

  logic        go, pc_bad, valid, exec, fault, need_mem, cnd, commit;
  logic [63:0] val_a, val_b, val_e, maddr, laddr;
  logic        sa, sb, se, of_n;

  always_comb begin
    valid = (item.icode <= I_POP) &&
            !(item.icode == I_OPQ && item.ifun > F_XOR) &&
            !((item.icode == I_CMOV || item.icode == I_JXX) && item.ifun > C_G);
    go     = !item.mode && status == ST_AOK;
    pc_bad = pc >= 64'(MEM_BYTES);
    exec   = go && !pc_bad && valid;

    case (item.icode)
      I_CMOV, I_RMMOV, I_OPQ, I_PUSH:
        val_a = (item.reg_a == REG_NONE) ? 64'd0 : regs[item.reg_a];
      I_RET, I_POP: val_a = regs[REG_SP];
      default:      val_a = 64'd0;
    endcase
    case (item.icode)
      I_RMMOV, I_MRMOV, I_OPQ:
        val_b = (item.reg_b == REG_NONE) ? 64'd0 : regs[item.reg_b];
      I_CALL, I_RET, I_PUSH, I_POP: val_b = regs[REG_SP];
      default: val_b = 64'd0;
    endcase

    cnd = 1'b0;
    case (item.icode)
      I_CMOV: begin
        val_e = val_a;
        cnd   = cond_eval(item.ifun, zf, sf, of);
      end
      I_JXX: begin
        val_e = 64'd0;
        cnd   = cond_eval(item.ifun, zf, sf, of);
      end
      I_IRMOV:          val_e = item.const_value;
      I_RMMOV, I_MRMOV: val_e = val_b + item.const_value;
      I_OPQ: begin
        case (item.ifun)
          F_ADD:   val_e = val_b + val_a;
          F_SUB:   val_e = val_b - val_a;
          F_AND:   val_e = val_b & val_a;
          default: val_e = val_b ^ val_a;
        endcase
      end
      I_CALL, I_PUSH: val_e = val_b - 64'd8;
      I_RET, I_POP:   val_e = val_b + 64'd8;
      default:        val_e = 64'd0;
    endcase

    sa = val_a[63];
    sb = val_b[63];
    se = val_e[63];
    case (item.ifun)
      F_ADD:   of_n = (sa == sb) && (se != sa);
      F_SUB:   of_n = (sa != sb) && (se != sb);
      default: of_n = 1'b0;
    endcase

    case (item.icode)
      I_RMMOV, I_MRMOV, I_CALL, I_PUSH: begin
        maddr = val_e;
        need_mem = 1'b1;
      end
      I_RET, I_POP: begin
        maddr = val_a;
        need_mem = 1'b1;
      end
      default: begin
        maddr = val_e;
        need_mem = 1'b0;
      end
    endcase
    fault  = exec && need_mem && (maddr > LAST_OK);
    commit = exec && !fault;

    laddr = {52'd0, item.load_address};
    if (item.mode) begin
      req.we    = laddr <= LAST_OK;
      req.re    = 1'b0;
      req.addr  = laddr;
      req.wdata = item.load_word;
    end else begin
      req.we    = commit && (item.icode == I_RMMOV || item.icode == I_PUSH ||
                             item.icode == I_CALL);
      req.re    = commit && (item.icode == I_MRMOV || item.icode == I_RET ||
                             item.icode == I_POP);
      req.addr  = maddr;
      req.wdata = (item.icode == I_CALL) ? item.fall_through_pc : val_a;
    end

    if (!go)                   wb.st = status;
    else if (pc_bad || fault)  wb.st = ST_ADR;
    else if (!valid)           wb.st = ST_INS;
    else if (item.icode == I_HALT) wb.st = ST_HLT;
    else                       wb.st = status;

    wb.commit = commit;
    wb.is_ret = item.icode == I_RET;
    if ((item.icode == I_JXX && cnd) || item.icode == I_CALL) begin
      wb.npc = item.const_value;
    end else begin
      wb.npc = item.fall_through_pc;
    end

    wb.dst_e = REG_NONE;
    wb.dst_m = REG_NONE;
    if (commit) begin
      case (item.icode)
        I_CMOV:                       wb.dst_e = cnd ? item.reg_b : REG_NONE;
        I_IRMOV, I_OPQ:               wb.dst_e = item.reg_b;
        I_CALL, I_RET, I_PUSH, I_POP: wb.dst_e = REG_SP;
        default:                      wb.dst_e = REG_NONE;
      endcase
      if (item.icode == I_MRMOV || item.icode == I_POP) begin
        wb.dst_m = item.reg_a;
      end
    end

    wb.val_e  = exec ? val_e : 64'd0;
    wb.cnd    = exec & cnd;
    wb.fl_we  = commit && item.icode == I_OPQ;
    wb.zf     = val_e == 64'd0;
    wb.sf     = se;
    wb.of     = of_n;
    wb.mem_rd = req.re;
  end

endmodule

>>> sv/y86_instruction_execute_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// y86_instruction_execute_core
// Y86-64 sequential executor: decoded instructions or memory preloads in,
// one result item with status, PC, condition, valE, valM and flags out.
// ---------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one item per instruction (s_tuser = mode: 0 execute,
//   1 preload eight bytes). The m_ channel returns exactly one result item for
//   each input item, in order.
//   An item is held in an input register, then decoded and executed
//   combinationally, which also issues the data memory access. The result
//   waits in the write-back register until the registered memory word is
//   available and the output register is free, then is written back and
//   sent to the output register. No new item executes before the last is
//   written back, due to the execute/write-back loop through the register
//   file and the synchronous memory read. After reset the data memory is
//   cleared one eight-byte row per cycle; items are not processed meanwhile.
//   Registers, PC, flags and status reset to zero (AOK).
//   When the receiver stalls, the result stays in the output register, the
//   next item still executes into the write-back stage and one more is taken
//   into the input register; after that s_tready stays low.
// ---------------------------------------------------------------------------
module y86_instruction_execute_core import y86ie_pkg::*; #(
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // icode[3:0], ifun[7:4], reg_a[11:8], reg_b[15:12], const_value[79:16],
  // fall_through_pc[143:80], load_address[155:144], load_word[219:156], 0s
  input  logic [223:0] s_tdata,
  // mode[0]
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[1:0], new_pc[65:2], condition[66], exec_value[130:67],
  // mem_value[194:131], zero_flag[195], sign_flag[196], overflow_flag[197], 0s
  output logic [199:0] m_tdata
);

  localparam int AW = $clog2(MEM_BYTES);

  item_t       item;
  logic        in_v, w_v, out_v;
  wb_t         wb, wb_next;
  memreq_t     req;
  regs_t       regs;
  status_t     status;
  logic [63:0] pc, rdata, val_m, pc_new;
  logic        zf, sf, of, busy, e_fire, w_fire;
  logic [199:0] out_data;

  assign e_fire   = in_v && !w_v && !busy;
  assign w_fire   = w_v && (!out_v || m_tready);
  assign s_tready = !in_v || e_fire;

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.mode            <= s_tuser;
      item.icode           <= s_tdata[3:0];
      item.ifun            <= s_tdata[7:4];
      item.reg_a           <= s_tdata[11:8];
      item.reg_b           <= s_tdata[15:12];
      item.const_value     <= s_tdata[79:16];
      item.fall_through_pc <= s_tdata[143:80];
      item.load_address    <= s_tdata[155:144];
      item.load_word       <= s_tdata[219:156];
    end
  end

  y86ie_exec #(.MEM_BYTES(MEM_BYTES)) u_exec (
    .item   (item),
    .regs   (regs),
    .status (status),
    .pc     (pc),
    .zf     (zf),
    .sf     (sf),
    .of     (of),
    .req    (req),
    .wb     (wb_next)
  );

  y86ie_mem #(.MEM_BYTES(MEM_BYTES), .AW(AW)) u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (e_fire && req.we),
    .re    (e_fire && req.re),
    .addr  (req.addr[AW-1:0]),
    .wdata (req.wdata),
    .rdata (rdata),
    .busy  (busy)
  );

  always_ff @(posedge clk) begin
    if (e_fire) begin
      wb <= wb_next;
    end
  end

  assign val_m  = wb.mem_rd ? rdata : 64'd0;
  assign pc_new = !wb.commit ? pc : (wb.is_ret ? val_m : wb.npc);

  always_comb begin
    out_data         = '0;
    out_data[1:0]    = wb.st;
    out_data[65:2]   = pc_new;
    out_data[66]     = wb.cnd;
    out_data[130:67] = wb.val_e;
    out_data[194:131] = val_m;
    out_data[195]    = wb.fl_we ? wb.zf : zf;
    out_data[196]    = wb.fl_we ? wb.sf : sf;
    out_data[197]    = wb.fl_we ? wb.of : of;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v   <= 1'b0;
      w_v    <= 1'b0;
      out_v  <= 1'b0;
      status <= ST_AOK;
      pc     <= 64'd0;
      zf     <= 1'b0;
      sf     <= 1'b0;
      of     <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= 64'd0;
      end
    end else begin
      if (s_tvalid && s_tready) begin
        in_v <= 1'b1;
      end else if (e_fire) begin
        in_v <= 1'b0;
      end
      if (e_fire) begin
        w_v <= 1'b1;
      end else if (w_fire) begin
        w_v <= 1'b0;
      end
      if (w_fire) begin
        out_v <= 1'b1;
      end else if (m_tready) begin
        out_v <= 1'b0;
      end
      if (w_fire) begin
        status <= wb.st;
        pc     <= pc_new;
        if (wb.fl_we) begin
          zf <= wb.zf;
          sf <= wb.sf;
          of <= wb.of;
        end
        // The loaded word is written last so it wins over the stack pointer.
        if (wb.dst_e != REG_NONE) begin
          regs[wb.dst_e] <= wb.val_e;
        end
        if (wb.dst_m != REG_NONE) begin
          regs[wb.dst_m] <= val_m;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (w_fire) begin
      m_tdata <= out_data;
    end
  end

  assign m_tvalid = out_v;

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Y86-64 execute core testbench
// Drives preloads and decoded instructions into the core, predicts every
// result item with a behavioral model of the machine state and compares the
// outputs field by field, under random idling on both sides.
// ---------------------------------------------------------------------------
module tb_top;
  import y86ie_pkg::*;

  localparam int MEMB = MEM_BYTES_DEF;
  localparam longint LIMIT = 400000;

  typedef struct packed {
    logic [1:0]  st;
    logic [63:0] pc;
    logic        cnd;
    logic [63:0] ve;
    logic [63:0] vm;
    logic        zf;
    logic        sf;
    logic        of;
  } res_t;

  class exec_scoreboard;
    logic [63:0] regs [NUM_REGS];
    logic [7:0]  mem [MEMB];
    logic [63:0] pc;
    logic        zf, sf, of;
    logic [1:0]  st;
    res_t        pending[$];
    int          errors;

    function void clear();
      foreach (regs[i]) regs[i] = '0;
      foreach (mem[i]) mem[i] = '0;
      pc = '0; zf = 0; sf = 0; of = 0; st = ST_AOK; errors = 0;
    endfunction

    function logic [63:0] rd(logic [3:0] id);
      return (id == REG_NONE) ? 64'd0 : regs[id];
    endfunction

    function void wr(logic [3:0] id, logic [63:0] v);
      if (id != REG_NONE) regs[id] = v;
    endfunction

    function logic [63:0] ld(logic [63:0] a);
      logic [63:0] v;
      for (int i = 0; i < 8; i++) v[8*i +: 8] = mem[a + i];
      return v;
    endfunction

    function void sto(logic [63:0] a, logic [63:0] v);
      for (int i = 0; i < 8; i++) mem[a + i] = v[8*i +: 8];
    endfunction

    function logic flags_cond(logic [3:0] fn);
      logic lt;
      lt = sf ^ of;
      case (fn)
        C_ALW: return 1'b1;
        C_LE:  return lt | zf;
        C_L:   return lt;
        C_E:   return zf;
        C_NE:  return ~zf;
        C_GE:  return ~lt;
        C_G:   return ~lt & ~zf;
        default: return 1'b0;
      endcase
    endfunction

    function void note_item(item_t it);
      logic [63:0] va, vb, ve, vm, npc;
      logic        c, fault;
      res_t        r;
      va = 0; vb = 0; ve = 0; vm = 0; c = 0; fault = 0;
      if (it.mode) begin
        if (it.load_address <= MEMB - 8) sto(it.load_address, it.load_word);
      end else if (st != ST_AOK) begin
      end else if (pc >= MEMB) begin
        st = ST_ADR;
      end else if (it.icode > I_POP || (it.icode == I_OPQ && it.ifun > F_XOR) ||
                   ((it.icode == I_CMOV || it.icode == I_JXX) && it.ifun > C_G)) begin
        st = ST_INS;
      end else begin
        npc = it.fall_through_pc;
        case (it.icode)
          I_CMOV, I_RMMOV, I_OPQ, I_PUSH: va = rd(it.reg_a);
          I_RET, I_POP: va = regs[REG_SP];
          default: ;
        endcase
        case (it.icode)
          I_RMMOV, I_MRMOV, I_OPQ: vb = rd(it.reg_b);
          I_CALL, I_RET, I_PUSH, I_POP: vb = regs[REG_SP];
          default: ;
        endcase
        case (it.icode)
          I_HALT: st = ST_HLT;
          I_CMOV: begin ve = va; c = flags_cond(it.ifun); end
          I_IRMOV: ve = it.const_value;
          I_RMMOV, I_MRMOV: ve = vb + it.const_value;
          I_OPQ: begin
            case (it.ifun)
              F_ADD: ve = vb + va;
              F_SUB: ve = vb - va;
              F_AND: ve = vb & va;
              default: ve = vb ^ va;
            endcase
            zf = (ve == 0);
            sf = ve[63];
            if (it.ifun == F_ADD) of = (va[63] == vb[63]) && (ve[63] != va[63]);
            else if (it.ifun == F_SUB) of = (va[63] != vb[63]) && (ve[63] != vb[63]);
            else of = 0;
          end
          I_JXX: c = flags_cond(it.ifun);
          I_CALL, I_PUSH: ve = vb - 8;
          I_RET, I_POP: ve = vb + 8;
          default: ;
        endcase
        case (it.icode)
          I_RMMOV, I_PUSH: if (ve <= MEMB - 8) sto(ve, va); else fault = 1;
          I_CALL: if (ve <= MEMB - 8) sto(ve, it.fall_through_pc); else fault = 1;
          I_MRMOV: if (ve <= MEMB - 8) vm = ld(ve); else fault = 1;
          I_RET, I_POP: if (va <= MEMB - 8) vm = ld(va); else fault = 1;
          default: ;
        endcase
        if (fault) begin
          st = ST_ADR;
          vm = 0;
        end else begin
          case (it.icode)
            I_CMOV: if (c) wr(it.reg_b, ve);
            I_IRMOV, I_OPQ: wr(it.reg_b, ve);
            I_MRMOV: wr(it.reg_a, vm);
            I_CALL, I_RET, I_PUSH: regs[REG_SP] = ve;
            I_POP: begin regs[REG_SP] = ve; wr(it.reg_a, vm); end
            default: ;
          endcase
          if (it.icode == I_JXX && c) npc = it.const_value;
          else if (it.icode == I_CALL) npc = it.const_value;
          else if (it.icode == I_RET) npc = vm;
          pc = npc;
        end
      end
      r = '{st, pc, c, ve, vm, zf, sf, of};
      pending.push_back(r);
    endfunction

    function void check_result(logic [199:0] d);
      res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result item %h", $time, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[1:0] !== e.st) begin
        $display("%0t: status exp %0d got %0d", $time, e.st, d[1:0]); errors++;
      end
      if (d[65:2] !== e.pc) begin
        $display("%0t: new_pc exp %h got %h", $time, e.pc, d[65:2]); errors++;
      end
      if (d[66] !== e.cnd) begin
        $display("%0t: condition exp %b got %b", $time, e.cnd, d[66]); errors++;
      end
      if (d[130:67] !== e.ve) begin
        $display("%0t: exec_value exp %h got %h", $time, e.ve, d[130:67]); errors++;
      end
      if (d[194:131] !== e.vm) begin
        $display("%0t: mem_value exp %h got %h", $time, e.vm, d[194:131]); errors++;
      end
      if (d[197:195] !== {e.of, e.sf, e.zf}) begin
        $display("%0t: flags(of,sf,zf) exp %b got %b", $time, {e.of, e.sf, e.zf},
                 d[197:195]);
        errors++;
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [223:0] s_tdata = '0;
  logic         s_tuser = 0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [199:0] m_tdata;

  exec_scoreboard sb;
  longint cycles = 0;
  bit     calm = 0;
  bit     hold_off = 0;
  bit     done = 0;

  always #5 clk = ~clk;

  y86_instruction_execute_core DUT (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Receiver: random stalls, none during the calm stretch; held off entirely during the long hold-off.
  always @(posedge clk) begin
    if (m_tvalid && m_tready) sb.check_result(m_tdata);
    if (hold_off) m_tready <= 1'b0;
    else m_tready <= calm || done || ($urandom_range(99) >= 18);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Sends one item, with an optional random idle gap ahead of it. The valid
  // stays high after acceptance until the next idle cycle or the next item.
  task automatic send_item(item_t it);
    if (!calm) begin
      while ($urandom_range(99) < 18) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser <= it.mode;
    s_tdata <= {4'd0, it.load_word, it.load_address, it.fall_through_pc,
                it.const_value, it.reg_b, it.reg_a, it.ifun, it.icode};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_item(it);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic item_t mk(logic [3:0] ic, logic [3:0] fn, logic [3:0] ra,
                               logic [3:0] rb, logic [63:0] c, logic [63:0] p);
    item_t it;
    it = '0;
    it.icode = ic; it.ifun = fn; it.reg_a = ra; it.reg_b = rb;
    it.const_value = c; it.fall_through_pc = p;
    it.load_address = $urandom_range(4095);
    it.load_word = rand64();
    return it;
  endfunction

  function automatic item_t mk_load(logic [11:0] a, logic [63:0] w);
    item_t it;
    it = mk(4'($urandom_range(15)), 4'($urandom_range(15)), 4'($urandom_range(15)),
            4'($urandom_range(15)), rand64(), rand64());
    it.mode = 1'b1; it.load_address = a; it.load_word = w;
    return it;
  endfunction

  // Address-like constant: mostly inside memory, sometimes just past it.
  function automatic logic [63:0] addr64();
    case ($urandom_range(9))
      0: return rand64();
      1: return 64'(MEMB - 8 + $urandom_range(8));
      default: return 64'($urandom_range(MEMB / 8 - 1) * 8);
    endcase
  endfunction

  function automatic item_t rand_instr();
    logic [3:0] ic, fn;
    logic [63:0] c, p;
    ic = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 11));
    case (ic)
      I_OPQ: fn = ($urandom_range(15) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
      I_CMOV, I_JXX:
        fn = ($urandom_range(15) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(6));
      default: fn = 4'($urandom_range(15));
    endcase
    c = ($urandom_range(2) == 0) ? rand64() : addr64();
    if (ic == I_IRMOV && $urandom_range(3) == 0) c = rand64() >> $urandom_range(63);
    p = ($urandom_range(9) == 0) ? rand64() : addr64();
    if (ic == I_HALT && $urandom_range(3) != 0) ic = I_NOP;
    return mk(ic, fn, 4'($urandom_range(15)), 4'($urandom_range(15)), c, p);
  endfunction

  initial begin
    item_t it;
    int    sent;
    sb = new();
    sb.clear();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: preload extremes, then every operation but halt.
    send_item(mk_load(12'd0, 64'hffff_ffff_ffff_ffff));
    send_item(mk_load(12'(MEMB - 8), 64'h0123_4567_89ab_cdef));
    send_item(mk_load(12'(MEMB - 7), 64'hdead_beef_0000_0001));
    send_item(mk_load(12'hfff, 64'h5555_aaaa_5555_aaaa));
    send_item(mk(I_IRMOV, 0, REG_NONE, REG_SP, 64'd2048, 64'd10));
    send_item(mk(I_IRMOV, 0, REG_NONE, 4'd0, 64'h7fff_ffff_ffff_ffff, 64'd20));
    send_item(mk(I_IRMOV, 0, REG_NONE, 4'd1, 64'h8000_0000_0000_0000, 64'd30));
    send_item(mk(I_OPQ, F_ADD, 4'd0, 4'd0, 0, 64'd32));
    send_item(mk(I_JXX, C_LE, 0, 0, 64'd100, 64'd41));
    send_item(mk(I_OPQ, F_SUB, 4'd0, 4'd1, 0, 64'd43));
    send_item(mk(I_CMOV, C_G, 4'd1, 4'd2, 0, 64'd45));
    send_item(mk(I_OPQ, F_AND, 4'd2, 4'd2, 0, 64'd47));
    send_item(mk(I_OPQ, F_XOR, 4'd1, 4'd1, 0, 64'd49));
    send_item(mk(I_CMOV, C_E, 4'd1, 4'd3, 0, 64'd51));
    send_item(mk(I_RMMOV, 0, 4'd0, REG_NONE, 64'd256, 64'd61));
    send_item(mk(I_MRMOV, 0, 4'd5, REG_NONE, 64'(MEMB - 8), 64'd71));
    send_item(mk(I_PUSH, 0, 4'd5, REG_NONE, 0, 64'd73));
    send_item(mk(I_POP, 0, REG_SP, REG_NONE, 0, 64'd75));
    send_item(mk(I_IRMOV, 0, REG_NONE, REG_SP, 64'd1024, 64'd85));
    send_item(mk(I_CALL, 0, REG_NONE, REG_NONE, 64'd500, 64'd94));
    send_item(mk(I_RET, 0, REG_NONE, REG_NONE, 0, 64'd501));
    send_item(mk(I_NOP, 0, REG_NONE, REG_NONE, 0, 64'd95));
    send_item(mk(I_JXX, C_NE, 0, 0, 64'd200, 64'd104));

    // Random: mostly valid instructions with preloads mixed in. A long
    // receiver hold-off runs in its own process meanwhile.
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 1;
        repeat (200) @(posedge clk);
        hold_off = 0;
      end
    join_none
    sent = 0;
    while (sent < 650) begin
      calm = (sent >= 300 && sent < 380);
      if ($urandom_range(6) == 0)
        it = mk_load(12'($urandom_range(4095)), rand64());
      else
        it = rand_instr();
      // A rare halt, bad opcode or out-of-range PC ends execution for good,
      // so those come only near the end of the run.
      if (sent < 600 && it.mode == 0 &&
          (it.icode == I_HALT || it.icode > I_POP ||
           (it.icode == I_OPQ && it.ifun > F_XOR) ||
           ((it.icode == I_CMOV || it.icode == I_JXX) && it.ifun > C_G)))
        it.icode = I_NOP;
      if (sent < 600 && it.mode == 0) begin
        if (it.fall_through_pc >= MEMB) it.fall_through_pc = 64'($urandom_range(MEMB - 1));
        if (it.icode == I_JXX && it.const_value >= MEMB)
          it.const_value = 64'($urandom_range(MEMB - 1));
        if (it.icode == I_CALL) it.const_value = 64'($urandom_range(MEMB - 1));
        if (it.icode inside {I_RMMOV, I_MRMOV} && $urandom_range(3) != 0) begin
          it.reg_b = REG_NONE;
          it.const_value = 64'($urandom_range(MEMB - 8));
        end
        if (it.icode inside {I_CALL, I_RET, I_PUSH, I_POP}) begin
          send_item(mk(I_IRMOV, 0, REG_NONE, REG_SP,
                       64'($urandom_range(1, MEMB / 8 - 1) * 8), 64'd0));
          sent++;
        end
        if (it.icode == I_RET && (sb.ld(sb.regs[REG_SP]) >= MEMB)) begin
          send_item(mk_load(12'(sb.regs[REG_SP]), 64'($urandom_range(MEMB - 1))));
          sent++;
        end
      end
      send_item(it);
      sent++;
    end
    s_tvalid <= 1'b0;
    calm = 0;
    done = 1;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end
endmodule
